@@ sv/srbs_pkg.sv @@
// Shared constants, codes, types and helpers of the shortest-remaining-burst scheduler.
package srbs_pkg;

  // Table depth and derived widths
  localparam int MAX_PROCS = 256;
  localparam int OCC_W     = $clog2(MAX_PROCS + 1);

  // Field widths fixed by the request and result formats
  localparam int ID_W      = 8;
  localparam int NUM_IDS   = 256;
  localparam int BURST_W   = 16;
  localparam int WORD_W    = 32;
  localparam int CREATED_W = 9;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 3;

  localparam logic [CREATED_W-1:0] CREATED_MAX = 9'd511;
  localparam logic [CREATED_W-1:0] LIMIT_RESET = 9'd200;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARRIVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_RAN      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RETIRED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HALTED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_POP,
    OP_RUN,
    OP_RUN_INS
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [WORD_W-1:0]  wait_cnt;
  } slot_data_t;

  typedef struct packed {
    logic       valid;
    slot_data_t data;
  } slot_t;

  typedef struct packed {
    cell_op_t           op;
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [WORD_W-1:0]  wait_cnt;
  } cell_cmd_t;

  // Saturating increment of a 32-bit count
  function automatic logic [WORD_W-1:0] sat_inc32(input logic [WORD_W-1:0] x);
    sat_inc32 = (x == '1) ? x : x + WORD_W'(1);
  endfunction

endpackage

@@ sv/srbs_if.sv @@
// Request and result channel interfaces of the scheduler.
interface srbs_in_if;
  logic                         valid;
  logic                         ready;
  logic [srbs_pkg::KIND_W-1:0]  kind;
  logic [srbs_pkg::BURST_W-1:0] burst;

  modport source(output valid, kind, burst, input ready);
  modport sink(input valid, kind, burst, output ready);
endinterface

interface srbs_out_if;
  logic                           valid;
  logic                           ready;
  logic [srbs_pkg::STATUS_W-1:0]  status;
  logic [srbs_pkg::ID_W-1:0]      proc_id;
  logic [srbs_pkg::BURST_W-1:0]   remaining;
  logic [srbs_pkg::WORD_W-1:0]    wait_sum;
  logic                           switched;
  logic [srbs_pkg::WORD_W-1:0]    ticks_run;
  logic [srbs_pkg::WORD_W-1:0]    switches;
  logic [srbs_pkg::CREATED_W-1:0] created;

  modport source(output valid, status, proc_id, remaining, wait_sum, switched,
                 ticks_run, switches, created, input ready);
  modport sink(input valid, status, proc_id, remaining, wait_sum, switched,
               ticks_run, switches, created, output ready);
endinterface

@@ sv/shortest_remaining_burst_scheduler_unit.sv @@
// Top level of the shortest-remaining-burst scheduler: control, counters and result register.
//
// Requests arrive on in_req (kind, burst) with a valid/ready handshake; each one
// yields exactly one result on out_res. Kind 0 loads a process, kind 1 runs one
// tick of the front process (or retires it when its burst is zero), kind 2 does
// the same, inserting an arrival on a tick with room; kind 3 behaves as kind 1.
// cfg_we/cfg_wdata write the process limit at which stepping halts.
//
// A request is accepted in the idle state; at that same edge the per-id wait
// total of the front process is read into a registered memory output, and the
// request is later committed into the result register, which waits while the
// receiver stalls. out_res.valid rises at the commit edge; the accept/commit
// sequencer takes no new request until the last one has committed, around the
// registered read of the wait-total memory. The process chain itself inserts,
// pops and ages all slots in the commit cycle.
//
// Reset empties the chain, clears the wait totals through their valid bits and
// loads the limit with 200; no clearing pass is needed. When the receiver stalls
// the result stays in the output register, one more request is accepted and held
// until the register frees.
module shortest_remaining_burst_scheduler_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  srbs_in_if.sink                        in_req,
  srbs_out_if.source                     out_res,
  input  logic                           cfg_we,
  input  logic [srbs_pkg::CREATED_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic [srbs_pkg::STATUS_W-1:0]  status;
    logic [srbs_pkg::ID_W-1:0]      proc_id;
    logic [srbs_pkg::BURST_W-1:0]   remaining;
    logic [srbs_pkg::WORD_W-1:0]    wait_sum;
    logic                           switched;
  } res_t;

  state_t                         state_r, state_nxt;
  logic [srbs_pkg::KIND_W-1:0]    kind_r;
  logic [srbs_pkg::BURST_W-1:0]   burst_r;
  logic [srbs_pkg::CREATED_W-1:0] limit_r;
  logic [srbs_pkg::OCC_W-1:0]     occ_r, occ_nxt;
  logic [srbs_pkg::CREATED_W-1:0] created_r, created_nxt;
  logic [srbs_pkg::WORD_W-1:0]    run_ticks_r, run_ticks_nxt;
  logic [srbs_pkg::WORD_W-1:0]    switch_r, switch_nxt;
  logic                           out_valid_r;
  res_t                           res_r, res_nxt;

  srbs_pkg::cell_cmd_t            cmd;
  srbs_pkg::slot_t                front;
  logic [srbs_pkg::WORD_W-1:0]    total;
  logic [srbs_pkg::WORD_W:0]      total_sum;
  logic [srbs_pkg::WORD_W-1:0]    total_new;
  logic [srbs_pkg::ID_W-1:0]      new_id;
  logic                           accept, commit, full, halted, do_retire, new_front;
  logic                           mem_wr, mem_clr;

  srbs_chain u_chain (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .front(front)
  );

  srbs_wait_mem u_wait_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (front.data.id),
    .rd_data (total),
    .wr_en   (mem_wr),
    .wr_addr (front.data.id),
    .wr_data (total_new),
    .clr_en  (mem_clr),
    .clr_addr(new_id)
  );

  // Handshake
  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign commit       = (state_r == S_EXEC) && (!out_valid_r || out_res.ready);

  // Decode the held request
  assign full      = (occ_r == srbs_pkg::OCC_W'(srbs_pkg::MAX_PROCS));
  assign halted    = (occ_r == '0) || (created_r >= limit_r);
  assign do_retire = (front.data.burst == '0);
  assign new_id    = created_r[srbs_pkg::ID_W-1:0];
  assign new_front = (front.data.burst - srbs_pkg::BURST_W'(1)) > burst_r;
  assign total_sum = {1'b0, total} + {1'b0, front.data.wait_cnt};
  assign total_new = total_sum[srbs_pkg::WORD_W] ? '1 : total_sum[srbs_pkg::WORD_W-1:0];

  // Work out the chain operation, counter updates and result
  always_comb begin
    cmd           = '{op: srbs_pkg::OP_HOLD, id: new_id, burst: burst_r, wait_cnt: '0};
    res_nxt       = '{status: srbs_pkg::ST_HALTED, proc_id: '0, remaining: '0,
                      wait_sum: '0, switched: 1'b0};
    occ_nxt       = occ_r;
    created_nxt   = created_r;
    run_ticks_nxt = run_ticks_r;
    switch_nxt    = switch_r;
    mem_wr        = 1'b0;
    mem_clr       = 1'b0;
    if (kind_r == srbs_pkg::KIND_LOAD) begin
      if (full) begin
        res_nxt.status = srbs_pkg::ST_REJECTED;
      end else begin
        res_nxt.status    = srbs_pkg::ST_LOADED;
        res_nxt.proc_id   = new_id;
        res_nxt.remaining = burst_r;
        cmd.op            = srbs_pkg::OP_LOAD;
        mem_clr           = 1'b1;
        occ_nxt           = occ_r + srbs_pkg::OCC_W'(1);
        created_nxt       = (created_r == srbs_pkg::CREATED_MAX) ?
                            created_r : created_r + srbs_pkg::CREATED_W'(1);
      end
    end else if (halted) begin
      res_nxt.status = srbs_pkg::ST_HALTED;
    end else if (do_retire) begin
      res_nxt.status   = srbs_pkg::ST_RETIRED;
      res_nxt.proc_id  = front.data.id;
      res_nxt.wait_sum = total;
      res_nxt.switched = 1'b1;
      cmd.op           = srbs_pkg::OP_POP;
      occ_nxt          = occ_r - srbs_pkg::OCC_W'(1);
      switch_nxt       = srbs_pkg::sat_inc32(switch_r);
    end else begin
      res_nxt.status    = srbs_pkg::ST_RAN;
      res_nxt.proc_id   = front.data.id;
      res_nxt.remaining = front.data.burst - srbs_pkg::BURST_W'(1);
      res_nxt.wait_sum  = total_new;
      run_ticks_nxt     = srbs_pkg::sat_inc32(run_ticks_r);
      mem_wr            = 1'b1;
      cmd.op            = srbs_pkg::OP_RUN;
      if (kind_r == srbs_pkg::KIND_ARRIVE && !full) begin
        cmd.op       = srbs_pkg::OP_RUN_INS;
        cmd.wait_cnt = srbs_pkg::WORD_W'(1);
        mem_clr      = 1'b1;
        occ_nxt      = occ_r + srbs_pkg::OCC_W'(1);
        created_nxt  = (created_r == srbs_pkg::CREATED_MAX) ?
                       created_r : created_r + srbs_pkg::CREATED_W'(1);
        if (new_front && (new_id != front.data.id)) begin
          res_nxt.switched = 1'b1;
          switch_nxt       = srbs_pkg::sat_inc32(switch_r);
        end
      end
    end
    // Drop everything unless the request commits now
    if (!commit) begin
      cmd.op        = srbs_pkg::OP_HOLD;
      occ_nxt       = occ_r;
      created_nxt   = created_r;
      run_ticks_nxt = run_ticks_r;
      switch_nxt    = switch_r;
      mem_wr        = 1'b0;
      mem_clr       = 1'b0;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= srbs_pkg::LIMIT_RESET;
      occ_r       <= '0;
      created_r   <= '0;
      run_ticks_r <= '0;
      switch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      created_r   <= created_nxt;
      run_ticks_r <= run_ticks_nxt;
      switch_r    <= switch_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_req.kind;
      burst_r <= in_req.burst;
    end
    if (commit) begin
      res_r <= res_nxt;
    end
  end

  // Result channel; totals follow the committed request
  assign out_res.valid     = out_valid_r;
  assign out_res.status    = res_r.status;
  assign out_res.proc_id   = res_r.proc_id;
  assign out_res.remaining = res_r.remaining;
  assign out_res.wait_sum  = res_r.wait_sum;
  assign out_res.switched  = res_r.switched;
  assign out_res.ticks_run = run_ticks_r;
  assign out_res.switches  = switch_r;
  assign out_res.created   = created_r;

  // Occupancy never passes the chain length
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= srbs_pkg::OCC_W'(srbs_pkg::MAX_PROCS))
    else $error("occupancy above chain length");

  // The front cell is filled exactly when the count says the chain is not empty
  a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
    front.valid == (occ_r != '0))
    else $error("front cell valid disagrees with occupancy");

  // A retiring step always reports a context switch
  a_retire_switch: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (kind_r != srbs_pkg::KIND_LOAD) && !halted && do_retire |=>
      out_res.valid && out_res.switched && (out_res.status == srbs_pkg::ST_RETIRED))
    else $error("retire without switch");

  // Execution tick count never falls
  a_ticks_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> run_ticks_r >= $past(run_ticks_r))
    else $error("tick count decreased");

endmodule

@@ sv/srbs_cell.sv @@
// One slot of the sorted process chain: holds a process and trades it with its neighbors.
module srbs_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                is_front,
  input  srbs_pkg::cell_cmd_t cmd,
  input  srbs_pkg::slot_t     left_post,
  input  logic                left_after,
  input  srbs_pkg::slot_t     right_q,
  output srbs_pkg::slot_t     post,
  output logic                after,
  output srbs_pkg::slot_t     q
);

  logic                 valid_r, valid_nxt;
  srbs_pkg::slot_data_t data_r, data_nxt;

  assign q = '{valid: valid_r, data: data_r};

  // Apply the tick: front burst drops, waits rise, front wait clears
  always_comb begin
    post = q;
    if (cmd.op == srbs_pkg::OP_RUN || cmd.op == srbs_pkg::OP_RUN_INS) begin
      if (is_front) begin
        post.data.burst    = data_r.burst - srbs_pkg::BURST_W'(1);
        post.data.wait_cnt = '0;
      end else begin
        post.data.wait_cnt = srbs_pkg::sat_inc32(data_r.wait_cnt);
      end
    end
  end

  // This slot lies at or behind the insert point
  assign after = !post.valid || (post.data.burst > cmd.burst);

  // Pick the next content: keep, shift in from a neighbor, or take the new process
  always_comb begin
    valid_nxt = post.valid;
    data_nxt  = post.data;
    case (cmd.op) inside
      srbs_pkg::OP_POP: begin
        valid_nxt = right_q.valid;
        data_nxt  = right_q.data;
      end
      srbs_pkg::OP_LOAD, srbs_pkg::OP_RUN_INS: begin
        if (after && !left_after) begin
          valid_nxt         = 1'b1;
          data_nxt.id       = cmd.id;
          data_nxt.burst    = cmd.burst;
          data_nxt.wait_cnt = is_front ? '0 : cmd.wait_cnt;
        end else if (after) begin
          valid_nxt = left_post.valid;
          data_nxt  = left_post.data;
        end
      end
      default: begin
        valid_nxt = post.valid;
        data_nxt  = post.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

@@ sv/srbs_chain.sv @@
// Row of slot cells kept sorted by remaining burst, front at cell zero.
module srbs_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  srbs_pkg::cell_cmd_t cmd,
  output srbs_pkg::slot_t     front
);

  srbs_pkg::slot_t post_w      [srbs_pkg::MAX_PROCS];
  srbs_pkg::slot_t left_post_w [srbs_pkg::MAX_PROCS];
  srbs_pkg::slot_t q_w         [srbs_pkg::MAX_PROCS+1];
  logic            after_w     [srbs_pkg::MAX_PROCS];
  logic            left_after_w[srbs_pkg::MAX_PROCS];

  // Empty slot beyond the tail feeds the last cell on a pop
  assign q_w[srbs_pkg::MAX_PROCS] = '0;
  assign front = q_w[0];

  for (genvar i = 0; i < srbs_pkg::MAX_PROCS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_post_w[i]  = '0;
      assign left_after_w[i] = 1'b0;
    end else begin : g_body
      assign left_post_w[i]  = post_w[i-1];
      assign left_after_w[i] = after_w[i-1];
    end

    srbs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .is_front  (i == 0),
      .cmd       (cmd),
      .left_post (left_post_w[i]),
      .left_after(left_after_w[i]),
      .right_q   (q_w[i+1]),
      .post      (post_w[i]),
      .after     (after_w[i]),
      .q         (q_w[i])
    );
  end

endmodule

@@ sv/srbs_wait_mem.sv @@
// Per-id wait totals: one-port-write memory with registered read and per-entry valid bits.
module srbs_wait_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [srbs_pkg::ID_W-1:0]   rd_addr,
  output logic [srbs_pkg::WORD_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [srbs_pkg::ID_W-1:0]   wr_addr,
  input  logic [srbs_pkg::WORD_W-1:0] wr_data,
  input  logic                        clr_en,
  input  logic [srbs_pkg::ID_W-1:0]   clr_addr
);

  logic [srbs_pkg::WORD_W-1:0]  mem [srbs_pkg::NUM_IDS];
  logic [srbs_pkg::NUM_IDS-1:0] valid_r, valid_nxt;
  logic [srbs_pkg::WORD_W-1:0]  rd_data_r;
  logic                         rd_valid_r;

  // Write the data array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read registered, valid bit alongside
  always_ff @(posedge clk) begin
    rd_data_r  <= mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
  end

  // Mark written entries; a clear in the same cycle wins
  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
    if (clr_en) begin
      valid_nxt[clr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule
